[hw/rtl/tre_pkg.sv]
// ----------------------------------------------------------------------------
// tre_pkg
// Types, constants and the per-pixel packet decision shared by the TGA RLE
// pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

	localparam int OFFSET_BITS = 28;
	localparam int PIX_BITS    = 32;
	localparam int COL_BITS    = 16;
	localparam int CFG_BITS    = OFFSET_BITS;
	localparam int NUM_SLOTS   = 7;
	localparam int SLOT_BITS   = 3;
	localparam int RES_BITS    = OFFSET_BITS + PIX_BITS + 3 + 1;
	localparam int M_BITS      = ((RES_BITS + 7) / 8) * 8;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_KEEP_ALPHA = 2'd1;
	localparam logic [1:0] REG_BYTE_LIMIT = 2'd2;

	// Header byte values.
	localparam logic [7:0] HDR_RUN_OPEN = 8'd127;
	localparam logic [7:0] HDR_RUN_FULL = 8'd254;
	localparam logic [7:0] HDR_RAW_OPEN = 8'd255;
	localparam logic [7:0] HDR_RAW_FULL = 8'd127;

	localparam logic [2:0] SIZE_HEADER = 3'd1;
	localparam logic [2:0] SIZE_BGR    = 3'd3;
	localparam logic [2:0] SIZE_BGRA   = 3'd4;

	typedef struct packed {
		logic [COL_BITS-1:0]    row_width;
		logic                   keep_alpha;
		logic [OFFSET_BITS-1:0] byte_limit;
	} cfg_t;

	// One memory write; the first member lands in the highest bits.
	typedef struct packed {
		logic                   too_large;
		logic [2:0]             size;
		logic [PIX_BITS-1:0]    data;
		logic [OFFSET_BITS-1:0] offset;
	} res_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]    held_pixel;
		logic                   held_valid;
		logic [COL_BITS-1:0]    column_count;
		logic [OFFSET_BITS-1:0] out_offset;
		logic [OFFSET_BITS-1:0] header_offset;
		logic [7:0]             header_value;
		logic                   packet_open;
		logic                   in_run;
		logic                   overflowed;
	} enc_state_t;

	// Result of encoding one pixel: header before, pixel, header after.
	typedef struct packed {
		enc_state_t     st;
		logic [2:0]     vld;
		res_t [2:0]     slot;
	} enc_out_t;

	function automatic res_t tre_header(logic [OFFSET_BITS-1:0] off, logic [7:0] hv);
		res_t r;
		r           = '0;
		r.offset    = off;
		r.data      = {{(PIX_BITS-8){1'b0}}, hv};
		r.size      = SIZE_HEADER;
		return r;
	endfunction

	// Encodes one pixel against the packet state; next_eq tells whether the
	// following pixel is identical.
	function automatic enc_out_t tre_encode(enc_state_t s, logic [PIX_BITS-1:0] pix,
			logic next_eq, cfg_t cfg);
		enc_out_t               o;
		logic [COL_BITS-1:0]    w;
		logic [COL_BITS:0]      col_inc;
		logic                   last_col;
		logic [2:0]             n;
		logic [PIX_BITS-1:0]    bgra;
		logic [OFFSET_BITS-1:0] off;
		logic [OFFSET_BITS-1:0] hoff;
		logic [7:0]             hv;
		logic                   open;
		o        = '0;
		o.st     = s;
		w        = (cfg.row_width == '0) ? {{(COL_BITS-1){1'b0}}, 1'b1} : cfg.row_width;
		col_inc  = {1'b0, s.column_count} + {{COL_BITS{1'b0}}, 1'b1};
		last_col = (col_inc >= {1'b0, w});
		n        = cfg.keep_alpha ? SIZE_BGRA : SIZE_BGR;
		bgra     = {(cfg.keep_alpha ? pix[31:24] : 8'h00), pix[7:0], pix[15:8], pix[23:16]};
		off      = s.out_offset;
		hoff     = s.header_offset;
		hv       = s.header_value;
		open     = s.packet_open;
		if (s.out_offset >= cfg.byte_limit) begin
			o.st.overflowed      = 1'b1;
			o.vld[1]             = 1'b1;
			o.slot[1].too_large  = 1'b1;
		end else begin
			if (!last_col && next_eq && !(s.in_run && s.header_value == HDR_RUN_FULL)) begin
				if (!s.in_run) begin
					if (open) begin
						o.vld[0]  = 1'b1;
						o.slot[0] = tre_header(hoff, hv);
					end
					hoff = off;
					hv   = HDR_RUN_OPEN;
					off  = off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
					open = 1'b1;
					o.vld[1]         = 1'b1;
					o.slot[1].offset = off;
					o.slot[1].data   = bgra;
					o.slot[1].size   = n;
					off  = off + {{(OFFSET_BITS-3){1'b0}}, n};
				end
				hv          = hv + 8'd1;
				o.st.in_run = 1'b1;
			end else begin
				if (s.in_run) begin
					hv        = hv + 8'd1;
					o.vld[2]  = 1'b1;
					o.slot[2] = tre_header(hoff, hv);
					open      = 1'b0;
				end else begin
					if (s.column_count == '0 && open) begin
						o.vld[0]  = 1'b1;
						o.slot[0] = tre_header(hoff, hv);
						open      = 1'b0;
					end
					if (!open) begin
						hoff = off;
						hv   = HDR_RAW_OPEN;
						off  = off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
						open = 1'b1;
					end
					o.vld[1]         = 1'b1;
					o.slot[1].offset = off;
					o.slot[1].data   = bgra;
					o.slot[1].size   = n;
					off = off + {{(OFFSET_BITS-3){1'b0}}, n};
					hv  = hv + 8'd1;
					if (hv == HDR_RAW_FULL) begin
						o.vld[2]  = 1'b1;
						o.slot[2] = tre_header(hoff, hv);
						open      = 1'b0;
					end
				end
				o.st.in_run = 1'b0;
			end
			o.st.out_offset    = off;
			o.st.header_offset = hoff;
			o.st.header_value  = hv;
			o.st.packet_open   = open;
			o.st.column_count  = last_col ? '0 : col_inc[COL_BITS-1:0];
		end
		return o;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tre_core.sv]
// ----------------------------------------------------------------------------
// tre_core
// Encoder state and the decision logic for one input pixel: up to two pixel
// encodings and a closing header, laid out in fixed result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_core
	import tre_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic [PIX_BITS-1:0]     pix,
	input  wire logic                    fin,
	input  wire cfg_t                    cfg,
	output logic      [NUM_SLOTS-1:0]    slot_vld,
	output res_t      [NUM_SLOTS-1:0]    slot
);

	enc_state_t st_q;
	enc_state_t st_nxt;
	enc_out_t   e1;
	enc_out_t   e2;

	always_comb begin
		st_nxt   = st_q;
		slot_vld = '0;
		slot     = '0;
		e1       = tre_encode(st_q, st_q.held_pixel, (st_q.held_pixel == pix), cfg);
		if (!st_q.overflowed && st_q.held_valid) begin
			st_nxt        = e1.st;
			slot_vld[2:0] = e1.vld;
			slot[2:0]     = e1.slot;
		end
		e2 = tre_encode(st_nxt, pix, 1'b0, cfg);
		if (fin) begin
			if (!st_nxt.overflowed) begin
				slot_vld[5:3] = e2.vld;
				slot[5:3]     = e2.slot;
				if (!e2.st.overflowed && e2.st.packet_open) begin
					slot_vld[6] = 1'b1;
					slot[6]     = tre_header(e2.st.header_offset, e2.st.header_value);
				end
			end
			// The image is finished: the stream starts over.
			st_nxt = '0;
		end else if (!st_nxt.overflowed) begin
			st_nxt.held_pixel = pix;
			st_nxt.held_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (load) begin
			st_q <= st_nxt;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tre_outq.sv]
// ----------------------------------------------------------------------------
// tre_outq
// Result register: holds the result slots of one input and hands out the
// valid ones in slot order, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_outq
	import tre_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic [NUM_SLOTS-1:0]    slot_vld,
	input  wire res_t [NUM_SLOTS-1:0]    slot,
	output logic                         can_load,
	output logic                         out_valid,
	output res_t                         out_res,
	output logic                         out_last,
	input  wire logic                    out_ready
);

	logic [NUM_SLOTS-1:0] mask_q;
	res_t [NUM_SLOTS-1:0] slot_q;
	logic [NUM_SLOTS-1:0] mask_rest;
	logic [SLOT_BITS-1:0] sel;

	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SLOT_BITS'(i);
			end
		end
	end

	// Dropping the lowest set bit leaves what is still to be sent.
	assign mask_rest = mask_q & (mask_q - {{(NUM_SLOTS-1){1'b0}}, 1'b1});
	assign out_valid = |mask_q;
	assign out_last  = (mask_rest == '0);
	assign out_res   = slot_q[sel];
	assign can_load  = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= slot_vld;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= slot;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tga_rle_pixel_encoder.sv]
// Path: an accepted pixel passes the input register, then the result register,
// before its first write is on the output.
// Throughput: one pixel per cycle while each pixel causes at most one write and
// m_tready is high; more writes hold the result register until the last is taken.
// Reset: arst_n clears the packet state and both registers at once and loads the
// configuration defaults (row width 1, alpha kept, byte limit all ones).
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder
// Streams RGBA pixels in and TGA run-length packets out as byte-offset writes.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_encoder
	import tre_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Pixel stream in. tdata: pixel_rgba[31:0]. tlast: final_pixel.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [PIX_BITS-1:0]    s_tdata,
	input  wire logic                   s_tlast,
	// Write stream out. tdata: write_offset, write_data[31:0], write_size[2:0],
	// too_large, from the lowest bit up. tlast: last_of_step.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [M_BITS-1:0]           m_tdata,
	output logic                        m_tlast,
	// Register writes, taken at any time; software writes them only while idle.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_BITS-1:0]    cfg_data
);

	cfg_t                  cfg_q;
	logic                  vld_s1;
	logic [PIX_BITS-1:0]   pix_s1;
	logic                  fin_s1;
	logic                  load;
	logic                  can_load;
	logic [NUM_SLOTS-1:0]  slot_vld;
	res_t [NUM_SLOTS-1:0]  slot;
	res_t                  out_res;

	assign cfg_ready = 1'b1;

	// Configuration registers. Writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width  <= {{(COL_BITS-1){1'b0}}, 1'b1};
			cfg_q.keep_alpha <= 1'b1;
			cfg_q.byte_limit <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_WIDTH:  cfg_q.row_width  <= cfg_data[COL_BITS-1:0];
				REG_KEEP_ALPHA: cfg_q.keep_alpha <= cfg_data[0];
				REG_BYTE_LIMIT: cfg_q.byte_limit <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The input register moves its pixel into the encoder whenever the result
	// register is free or is handing out its last write in this cycle, so a
	// fresh pixel can be taken in the same cycle.
	assign load     = vld_s1 && can_load;
	assign s_tready = !vld_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1 <= s_tdata;
			fin_s1 <= s_tlast;
		end
	end

	// The encoder works on the held lookahead pixel and the new one together,
	// and updates its state only when the results have a place to go.
	tre_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.pix      (pix_s1),
		.fin      (fin_s1),
		.cfg      (cfg_q),
		.slot_vld (slot_vld),
		.slot     (slot)
	);

	tre_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.slot_vld  (slot_vld),
		.slot      (slot),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

	assign m_tdata = {{(M_BITS-RES_BITS){1'b0}}, out_res};

endmodule

`default_nettype wire

[hw/rtl/tre_checker.sv]
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks for the TGA RLE pixel encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_checker
	import tre_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_BITS-1:0]    m_tdata,
	input wire logic                 m_tlast
);

	res_t r;
	assign r = m_tdata[RES_BITS-1:0];

	// A stalled write holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output write changed while stalled");

	// The overflow result is the last write of its step, and empty.
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.too_large |-> m_tlast && r.size == 3'd0 && r.offset == '0
			&& r.data == '0)
		else $error("overflow result malformed");

	// Ordinary writes are a header byte or a 3 or 4 byte pixel.
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r.too_large |-> r.size == SIZE_HEADER || r.size == SIZE_BGR
			|| r.size == SIZE_BGRA)
		else $error("bad write size");

	// A header carries one byte, a BGR pixel three.
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.size == SIZE_HEADER) |-> r.data[PIX_BITS-1:8] == '0)
		else $error("header wider than a byte");

	a_bgr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.size == SIZE_BGR) |-> r.data[PIX_BITS-1:24] == '0)
		else $error("three-byte pixel carries alpha");

endmodule

bind tga_rle_pixel_encoder tre_checker u_tre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);

`default_nettype wire

[dv/tre_write_check_pkg.sv]
// ----------------------------------------------------------------------------
// tre_write_check_pkg
// Expected-write tracker for the TGA RLE pixel encoder: predicts the memory
// writes of every accepted pixel and checks the block's writes against them.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_write_check_pkg;

	import tre_pkg::*;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] offset;
		logic [PIX_BITS-1:0]    data;
		logic [2:0]             wsize;
		logic                   too_large;
		logic                   last;
	} mem_write_t;

	class rle_write_tracker;
		logic [COL_BITS-1:0]    row_width;
		logic                   keep_alpha;
		logic [OFFSET_BITS-1:0] byte_limit;

		logic [PIX_BITS-1:0]    held_pixel;
		bit                     held_valid;
		logic [COL_BITS-1:0]    column;
		logic [OFFSET_BITS-1:0] out_offset;
		logic [OFFSET_BITS-1:0] header_offset;
		logic [7:0]             header_value;
		bit                     packet_open;
		bit                     in_run;
		bit                     overflowed;

		mem_write_t expected_writes[$];

		int errors;
		int n_pixels;
		int n_writes;
		int n_overflows;
		int n_run_packets;
		int n_raw_packets;
		int n_reg_writes;

		function new();
			row_width  = 16'd1;
			keep_alpha = 1'b1;
			byte_limit = '1;
			start_image();
		endfunction

		function void set_register(logic [1:0] index, logic [OFFSET_BITS-1:0] value);
			n_reg_writes++;
			case (index)
				REG_ROW_WIDTH:  row_width  = value[COL_BITS-1:0];
				REG_KEEP_ALPHA: keep_alpha = value[0];
				REG_BYTE_LIMIT: byte_limit = value;
				default: ;
			endcase
		endfunction

		// The packet state goes back to its reset value; registers and counters keep theirs.
		function void start_image();
			held_pixel    = '0;
			held_valid    = 1'b0;
			column        = '0;
			out_offset    = '0;
			header_offset = '0;
			header_value  = '0;
			packet_open   = 1'b0;
			in_run        = 1'b0;
			overflowed    = 1'b0;
		endfunction

		function void add_write(logic [OFFSET_BITS-1:0] offset, logic [PIX_BITS-1:0] data,
				logic [2:0] wsize, logic too_large);
			mem_write_t w;
			w.offset    = offset;
			w.data      = data;
			w.wsize     = wsize;
			w.too_large = too_large;
			w.last      = 1'b0;
			expected_writes.push_back(w);
		endfunction

		function void add_header();
			if (header_value[7])
				n_run_packets++;
			else
				n_raw_packets++;
			add_write(header_offset, {{(PIX_BITS-8){1'b0}}, header_value}, SIZE_HEADER, 1'b0);
		endfunction

		// The header byte is reserved now and written when the packet closes.
		function void open_packet(logic [7:0] start);
			header_offset = out_offset;
			header_value  = start;
			out_offset    = out_offset + OFFSET_BITS'(1);
			packet_open   = 1'b1;
		endfunction

		function void add_pixel(logic [PIX_BITS-1:0] pix);
			logic [PIX_BITS-1:0] bgra;
			logic [2:0]          n;
			n    = keep_alpha ? SIZE_BGRA : SIZE_BGR;
			bgra = {(keep_alpha ? pix[31:24] : 8'h00), pix[7:0], pix[15:8], pix[23:16]};
			add_write(out_offset, bgra, n, 1'b0);
			out_offset = out_offset + OFFSET_BITS'(n);
		endfunction

		function void encode(logic [PIX_BITS-1:0] pix, bit next_equal);
			int unsigned span;
			bit          last_col;
			span     = (row_width == '0) ? 1 : row_width;
			last_col = (32'(column) + 32'd1) >= span;
			if (out_offset >= byte_limit) begin
				overflowed = 1'b1;
				n_overflows++;
				add_write('0, '0, '0, 1'b1);
				return;
			end
			if (!last_col && next_equal && !(in_run && header_value == HDR_RUN_FULL)) begin
				// Start or extend a run; only its first pixel is stored.
				if (!in_run) begin
					if (packet_open)
						add_header();
					open_packet(HDR_RUN_OPEN);
					add_pixel(pix);
				end
				header_value = header_value + 8'd1;
				in_run       = 1'b1;
			end else begin
				if (in_run) begin
					header_value = header_value + 8'd1;
					add_header();
					packet_open = 1'b0;
				end else begin
					if (column == '0 && packet_open) begin
						add_header();
						packet_open = 1'b0;
					end
					if (!packet_open)
						open_packet(HDR_RAW_OPEN);
					add_pixel(pix);
					header_value = header_value + 8'd1;
					if (header_value == HDR_RAW_FULL) begin
						add_header();
						packet_open = 1'b0;
					end
				end
				in_run = 1'b0;
			end
			column = last_col ? '0 : column + COL_BITS'(1);
		endfunction

		// Called once per accepted pixel; queues the writes that it causes.
		function void note_pixel(logic [PIX_BITS-1:0] pix, bit fin);
			int queued;
			queued = expected_writes.size();
			n_pixels++;
			if (!overflowed && held_valid)
				encode(held_pixel, held_pixel == pix);
			if (fin) begin
				if (!overflowed) begin
					encode(pix, 1'b0);
					if (!overflowed && packet_open)
						add_header();
				end
				start_image();
			end else if (!overflowed) begin
				held_pixel = pix;
				held_valid = 1'b1;
			end
			if (expected_writes.size() > queued)
				expected_writes[expected_writes.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string name, logic [PIX_BITS-1:0] want,
				logic [PIX_BITS-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_write(mem_write_t got);
			mem_write_t want;
			n_writes++;
			if (expected_writes.size() == 0) begin
				$error("write with nothing expected: offset %0h data %0h size %0d",
					got.offset, got.data, got.wsize);
				errors++;
				return;
			end
			want = expected_writes.pop_front();
			compare_field("write_offset", want.offset, got.offset);
			compare_field("write_data", want.data, got.data);
			compare_field("write_size", want.wsize, got.wsize);
			compare_field("too_large", want.too_large, got.too_large);
			compare_field("last_of_step", want.last, got.last);
		endfunction
	endclass

endpackage

`default_nettype wire

[dv/tga_rle_pixel_encoder_test.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder_test
// Self-checking bench for the TGA RLE pixel encoder. Pixels go in through the
// slave stream, every write coming out of the master stream is compared in
// order with the writes that the tracker predicts, and the registers are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_encoder_test;

	timeunit 1ns;
	timeprecision 1ps;

	import tre_pkg::*;
	import tre_write_check_pkg::*;

	// Cycles allowed for a pixel that causes no write to leave the pipeline.
	localparam int IDLE_CYCLES  = 8;
	// Length of the one long receiver hold-off.
	localparam int HOLD_CYCLES  = 80;
	// Bound on the wait for outstanding writes at the end.
	localparam int DRAIN_LIMIT  = 20000;
	// The random part stops once this many pixels have been accepted overall.
	localparam int PIXEL_BUDGET = 215;

	// Receiver behavior, changed after each stretch of random length.
	typedef enum {READY_ALWAYS, READY_HALF, READY_RARE, READY_MOSTLY} ready_mode_t;
	// Kinds of pixel segments that make up a random image.
	typedef enum {SEG_RUN, SEG_RAW, SEG_FLICKER, SEG_LONG} seg_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [PIX_BITS-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_BITS-1:0]   m_tdata;
	logic                m_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	rle_write_tracker tracker;

	// Items left in the sender's current burst; zero means a gap comes next.
	int burst_left = 0;
	// Set by the stimulus to make the receiver hold off for HOLD_CYCLES.
	bit hold_req = 1'b0;

	always #2 clk = ~clk;

	tga_rle_pixel_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Offers one pixel and waits for it to be taken. Bursts of random length
	// are separated by random gaps; within a burst valid stays high.
	task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic fin);
		if (burst_left == 0) begin
			if (s_tvalid)
				s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_pixel(pix, fin);
		burst_left--;
	endtask

	// Stops offering and waits until every predicted write has come out, then
	// lets a pixel that causes no write drain from the pipeline.
	task automatic wait_idle();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		burst_left = 0;
		while (tracker.expected_writes.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	// One register write. The extra edge keeps valid low between writes, so that
	// back-to-back writes never lower and raise it in the same step.
	task automatic write_reg(input logic [1:0] index, input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_register(index, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A pixel drawn mostly at random; a small palette makes chance repeats.
	function automatic logic [PIX_BITS-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h80FF_0001;
			default: return $urandom();
		endcase
	endfunction

	// A run of identical pixels; the final flag goes on the last one only.
	task automatic send_run(input int len, input bit fin);
		logic [PIX_BITS-1:0] pix;
		pix = pick_pixel();
		for (int i = 0; i < len; i++)
			send_pixel(pix, fin && i == len - 1);
	endtask

	// Independent random pixels, which nearly always differ from each other.
	task automatic send_raw(input int len, input bit fin);
		for (int i = 0; i < len; i++)
			send_pixel($urandom(), fin && i == len - 1);
	endtask

	// One image, or part of one when fin is clear, built from segments:
	// runs, raw stretches, a pixel flickering in one bit (equality has to
	// look at all 32 bits), and now and then a long segment, cut short to
	// what is left of the count.
	task automatic send_image(input int count, input bit fin);
		int                  left;
		int                  len;
		int                  pick;
		seg_kind_t           kind;
		logic [PIX_BITS-1:0] base;
		logic [PIX_BITS-1:0] flip;
		bit                  ends;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 19);
			kind = (pick < 8) ? SEG_RUN : (pick < 15) ? SEG_RAW :
				(pick < 19) ? SEG_FLICKER : SEG_LONG;
			case (kind)
				SEG_RUN:     len = $urandom_range(2, 9);
				SEG_RAW:     len = $urandom_range(1, 6);
				SEG_FLICKER: len = $urandom_range(2, 5);
				default:     len = $urandom_range(120, 131);
			endcase
			if (len > left)
				len = left;
			ends = fin && len == left;
			case (kind)
				SEG_RUN:     send_run(len, ends);
				SEG_RAW:     send_raw(len, ends);
				SEG_FLICKER: begin
					base = pick_pixel();
					flip = base ^ (PIX_BITS'(1) << $urandom_range(0, PIX_BITS - 1));
					for (int i = 0; i < len; i++)
						send_pixel(i[0] ? flip : base, ends && i == len - 1);
				end
				default: begin
					if ($urandom_range(0, 1))
						send_run(len, ends);
					else
						send_raw(len, ends);
				end
			endcase
			left -= len;
		end
	endtask

	// Receiver: stretches of random length in one ready pattern each, and one
	// long hold-off on request while the sender keeps offering pixels.
	initial begin : receiver
		ready_mode_t mode;
		int          span;
		m_tready = 1'b0;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			while (span > 0 && !hold_req) begin
				case (mode)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
					READY_RARE:   m_tready <= ($urandom_range(0, 3) == 0);
					default:      m_tready <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
				span--;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Every accepted write is checked against the oldest prediction.
	always @(posedge clk) begin : output_monitor
		mem_write_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.offset    = m_tdata[OFFSET_BITS-1:0];
			got.data      = m_tdata[OFFSET_BITS +: PIX_BITS];
			got.wsize     = m_tdata[OFFSET_BITS + PIX_BITS +: 3];
			got.too_large = m_tdata[OFFSET_BITS + PIX_BITS + 3];
			got.last      = m_tlast;
			tracker.check_write(got);
		end
	end

	initial begin : stimulus
		int          pick;
		int          left;
		logic [15:0] width;
		logic [27:0] limit;

		tracker   = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROW_WIDTH;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: one pixel per row, so every packet is a single raw
		// pixel even when neighbors are equal; all-zero and all-one pixels.
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);

		// Three bytes per pixel. A run, then two pixels that differ only in
		// alpha (still unequal), the final one mid-row. The next image starts
		// with the same pixel, which must not join the previous packet.
		wait_idle();
		write_reg(REG_ROW_WIDTH, 28'd6);
		write_reg(REG_KEEP_ALPHA, 28'd0);
		send_pixel(32'h1122_3344, 1'b0);
		send_pixel(32'h1122_3344, 1'b0);
		send_pixel(32'h1122_3344, 1'b0);
		send_pixel(32'h5566_7788, 1'b0);
		send_pixel(32'hAA66_7788, 1'b1);
		send_pixel(32'hAA66_7788, 1'b0);
		send_pixel(32'hAA66_7788, 1'b1);

		// A row width of zero behaves as one.
		wait_idle();
		write_reg(REG_ROW_WIDTH, 28'd0);
		send_pixel(32'h0102_0304, 1'b0);
		send_pixel(32'h0102_0304, 1'b0);
		send_pixel(32'hFEDC_BA98, 1'b1);

		// Widest row, then the width shrinks mid-image below the current
		// column, which then counts as the last column.
		wait_idle();
		write_reg(REG_ROW_WIDTH, 28'd65535);
		write_reg(REG_KEEP_ALPHA, 28'd1);
		send_pixel(32'hCAFE_0001, 1'b0);
		send_pixel(32'hCAFE_0001, 1'b0);
		send_pixel(32'h1234_5678, 1'b0);
		wait_idle();
		write_reg(REG_ROW_WIDTH, 28'd2);
		send_pixel(32'h1234_5678, 1'b0);
		send_pixel(32'h9ABC_DEF0, 1'b1);

		// Byte limit reached on the third pixel: one overflow write, then
		// nothing until the image ends. With a limit of zero the first pixel
		// overflows at once.
		wait_idle();
		write_reg(REG_BYTE_LIMIT, 28'd9);
		send_pixel(32'h0A0B_0C0D, 1'b0);
		send_pixel(32'h1A1B_1C1D, 1'b0);
		send_pixel(32'h2A2B_2C2D, 1'b0);
		send_pixel(32'h3A3B_3C3D, 1'b0);
		send_pixel(32'h4A4B_4C4D, 1'b1);
		wait_idle();
		write_reg(REG_BYTE_LIMIT, 28'd0);
		send_pixel(32'h0BAD_F00D, 1'b1);

		// A full run packet: a run of 129 in a wide row, then a raw stretch.
		// The receiver holds off at the start while the sender keeps going,
		// so the pipeline fills and the input stalls.
		wait_idle();
		write_reg(REG_BYTE_LIMIT, '1);
		write_reg(REG_ROW_WIDTH, 28'd400);
		write_reg(REG_KEEP_ALPHA, 28'($urandom_range(0, 1)));
		hold_req   = 1'b1;
		burst_left = 200;
		send_run(129, 1'b0);
		send_raw(50, 1'b1);

		// Random phases, each with its own settings and one image or part of
		// one. An unfinished image carries over into the next settings.
		while (tracker.n_pixels < PIXEL_BUDGET) begin
			wait_idle();
			pick = $urandom_range(0, 7);
			case (pick)
				0:       width = 16'd0;
				1:       width = 16'd1;
				2:       width = 16'd2;
				3, 4:    width = 16'($urandom_range(3, 10));
				5:       width = 16'hFFFF;
				6:       width = 16'($urandom_range(100, 400));
				default: width = 16'($urandom());
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0:       limit = 28'd0;
				1, 2:    limit = 28'($urandom_range(1, 120));
				3:       limit = 28'hFFF_FFFE;
				default: limit = '1;
			endcase
			write_reg(REG_ROW_WIDTH, 28'(width));
			write_reg(REG_KEEP_ALPHA, 28'($urandom_range(0, 1)));
			write_reg(REG_BYTE_LIMIT, limit);
			send_image($urandom_range(6, 36), $urandom_range(0, 4) != 0);
		end

		// Wind down: wait for outstanding writes, with a bound, then a further
		// idle wait to catch anything extra.
		if (s_tvalid)
			s_tvalid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && tracker.expected_writes.size() != 0; i++)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		left = tracker.expected_writes.size();
		if (left != 0) begin
			$error("%0d predicted writes never came out", left);
			tracker.errors += left;
		end

		$display("Covered %0d pixels and %0d writes: %0d run and %0d raw packets closed,",
			tracker.n_pixels, tracker.n_writes, tracker.n_run_packets,
			tracker.n_raw_packets);
		$display("%0d overflows, %0d register writes between phases.",
			tracker.n_overflows, tracker.n_reg_writes);
		if (tracker.errors == 0)
			$display("tga_rle_pixel_encoder: match");
		else
			$display("tga_rle_pixel_encoder: mismatch");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin : watchdog
		#2_000_000;
		$display("tga_rle_pixel_encoder: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hw/rtl/tre_pkg.sv
hw/rtl/tre_core.sv
hw/rtl/tre_outq.sv
hw/rtl/tga_rle_pixel_encoder.sv
hw/rtl/tre_checker.sv
dv/tre_write_check_pkg.sv
dv/tga_rle_pixel_encoder_test.sv
